### sv/tfv_pkg.sv
// Shared types, constants and CRC function of the TLV frame validator.
package tfv_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int BYTE_BITS      = 8;
   localparam int FAULT_BITS     = 4;
   localparam int RSP_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_VALUE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ID_LOW          = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ID_HIGH         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIELD_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_FRAME_BYTES = 3'd4;

   localparam logic [BYTE_BITS-1:0] RESET_START_VALUE     = 8'hAA;
   localparam logic [BYTE_BITS-1:0] RESET_ID_LOW          = 8'h10;
   localparam logic [BYTE_BITS-1:0] RESET_ID_HIGH         = 8'h18;
   localparam logic [BYTE_BITS-1:0] RESET_FIELD_LIMIT     = 8'd8;
   localparam logic [BYTE_BITS-1:0] RESET_MIN_FRAME_BYTES = 8'd4;
   localparam logic [BYTE_BITS-1:0] MIN_FRAME_FLOOR       = 8'd4;

   localparam logic [BYTE_BITS-1:0] CRC_POLY = 8'h07;
   localparam logic [BYTE_BITS-1:0] CRC_INIT = 8'h00;

   localparam logic [FAULT_BITS-1:0] FAULT_NONE    = 4'd0;
   localparam logic [FAULT_BITS-1:0] FAULT_SHORT   = 4'd1;
   localparam logic [FAULT_BITS-1:0] FAULT_START   = 4'd2;
   localparam logic [FAULT_BITS-1:0] FAULT_ID      = 4'd3;
   localparam logic [FAULT_BITS-1:0] FAULT_COUNT   = 4'd4;
   localparam logic [FAULT_BITS-1:0] FAULT_HEADER  = 4'd5;
   localparam logic [FAULT_BITS-1:0] FAULT_PAYLOAD = 4'd6;
   localparam logic [FAULT_BITS-1:0] FAULT_LENGTH  = 4'd7;
   localparam logic [FAULT_BITS-1:0] FAULT_CRC     = 4'd8;

   typedef struct packed {
      logic [BYTE_BITS-1:0] start_value;
      logic [BYTE_BITS-1:0] id_low;
      logic [BYTE_BITS-1:0] id_high;
      logic [BYTE_BITS-1:0] field_limit;
      logic [BYTE_BITS-1:0] min_frame_bytes;
   } cfg_type;

   typedef struct packed {
      logic [FAULT_BITS-1:0] fault_code;
      logic [BYTE_BITS-1:0]  frame_id;
      logic [BYTE_BITS-1:0]  record_count;
   } verdict_type;

   function automatic logic [BYTE_BITS-1:0] crc8_next(input logic [BYTE_BITS-1:0] crc,
                                                      input logic [BYTE_BITS-1:0] b);
      logic [BYTE_BITS-1:0] v;
      v = crc ^ b;
      for (int k = 0; k < BYTE_BITS; k++) begin
         v = v[BYTE_BITS-1] ? ({v[BYTE_BITS-2:0], 1'b0} ^ CRC_POLY) : {v[BYTE_BITS-2:0], 1'b0};
      end
      return v;
   endfunction

endpackage

### sv/tfv_csr.sv
// Configuration registers of the TLV frame validator.
module tfv_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tfv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tfv_pkg::BYTE_BITS-1:0]      csr_data,
   output tfv_pkg::cfg_type                  cfg
);

   tfv_pkg::cfg_type cfg_ff;
   tfv_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tfv_pkg::CSR_START_VALUE:     cfg_in.start_value     = csr_data;
            tfv_pkg::CSR_ID_LOW:          cfg_in.id_low          = csr_data;
            tfv_pkg::CSR_ID_HIGH:         cfg_in.id_high         = csr_data;
            tfv_pkg::CSR_FIELD_LIMIT:     cfg_in.field_limit     = csr_data;
            tfv_pkg::CSR_MIN_FRAME_BYTES: cfg_in.min_frame_bytes = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value     <= tfv_pkg::RESET_START_VALUE;
         cfg_ff.id_low          <= tfv_pkg::RESET_ID_LOW;
         cfg_ff.id_high         <= tfv_pkg::RESET_ID_HIGH;
         cfg_ff.field_limit     <= tfv_pkg::RESET_FIELD_LIMIT;
         cfg_ff.min_frame_bytes <= tfv_pkg::RESET_MIN_FRAME_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/tfv_in_stage.sv
// Input register of the TLV frame validator.
module tfv_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tfv_pkg::BYTE_BITS-1:0] req_byte,
   input  logic                         req_last,
   input  logic                         advance,
   output logic                         item_valid,
   output logic [tfv_pkg::BYTE_BITS-1:0] item_byte,
   output logic                         item_last
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [tfv_pkg::BYTE_BITS-1:0] byte_ff;
   logic                         last_ff;
   logic                         load;

   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !advance);

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;
   assign item_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_byte;
         last_ff <= req_last;
      end
   end

endmodule

### sv/tfv_parser.sv
// Frame walk, CRC and verdict logic of the TLV frame validator.
module tfv_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [tfv_pkg::BYTE_BITS-1:0] rx_byte,
   input  logic                         last,
   input  tfv_pkg::cfg_type             cfg,
   output tfv_pkg::verdict_type         verdict
);

   typedef enum logic [2:0] {
      PH_START, PH_ID, PH_COUNT, PH_REC_ID, PH_REC_LEN, PH_PAYLOAD, PH_TRAILER, PH_EXTRA
   } phase_type;

   localparam logic [tfv_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [tfv_pkg::COUNT_BITS-1:0] POS_ID    = tfv_pkg::COUNT_BITS'(1);
   localparam logic [tfv_pkg::COUNT_BITS-1:0] POS_COUNT = tfv_pkg::COUNT_BITS'(2);

   phase_type                          phase_ff, phase_in, phase_walk;
   logic [tfv_pkg::COUNT_BITS-1:0]     bytes_ff, bytes_in;
   logic [tfv_pkg::BYTE_BITS-1:0]      crc_ff, crc_in;
   logic [tfv_pkg::BYTE_BITS-1:0]      id_ff, id_in;
   logic [tfv_pkg::BYTE_BITS-1:0]      declared_ff, declared_in;
   logic [tfv_pkg::BYTE_BITS-1:0]      done_ff, done_in, done_walk;
   logic [tfv_pkg::BYTE_BITS-1:0]      left_ff, left_in, left_walk;
   logic [tfv_pkg::FAULT_BITS-1:0]     fault_ff, fault_in, fault_walk;
   logic [tfv_pkg::BYTE_BITS-1:0]      done_next;
   logic [tfv_pkg::BYTE_BITS-1:0]      left_next;
   logic [tfv_pkg::COUNT_BITS-1:0]     frame_len;
   logic [tfv_pkg::BYTE_BITS-1:0]      min_len;
   logic                               saturated;

   assign saturated = (bytes_ff == COUNT_MAX);
   assign done_next = done_ff + 8'd1;
   assign left_next = left_ff - 8'd1;

   // header checks and record walk for one non-final byte
   always_comb begin
      phase_walk = phase_ff;
      done_walk  = done_ff;
      left_walk  = left_ff;
      fault_walk = fault_ff;
      unique case (phase_ff)
         PH_START: begin
            if (rx_byte != cfg.start_value) fault_walk = tfv_pkg::FAULT_START;
            phase_walk = PH_ID;
         end
         PH_ID: begin
            if (rx_byte < cfg.id_low || rx_byte > cfg.id_high) fault_walk = tfv_pkg::FAULT_ID;
            phase_walk = PH_COUNT;
         end
         PH_COUNT: begin
            if (rx_byte > cfg.field_limit) fault_walk = tfv_pkg::FAULT_COUNT;
            done_walk  = '0;
            phase_walk = (rx_byte == '0) ? PH_TRAILER : PH_REC_ID;
         end
         PH_REC_ID: begin
            phase_walk = PH_REC_LEN;
         end
         PH_REC_LEN: begin
            left_walk = rx_byte;
            if (rx_byte == '0) begin
               done_walk  = done_next;
               phase_walk = (done_next == declared_ff) ? PH_TRAILER : PH_REC_ID;
            end else begin
               phase_walk = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            left_walk = left_next;
            if (left_next == '0) begin
               done_walk  = done_next;
               phase_walk = (done_next == declared_ff) ? PH_TRAILER : PH_REC_ID;
            end
         end
         PH_TRAILER, PH_EXTRA: begin
            phase_walk = PH_EXTRA;
         end
         default: phase_walk = PH_EXTRA;
      endcase
   end

   // verdict for the final byte
   always_comb begin
      frame_len = saturated ? bytes_ff : bytes_ff + tfv_pkg::COUNT_BITS'(1);
      min_len   = (cfg.min_frame_bytes < tfv_pkg::MIN_FRAME_FLOOR) ?
                  tfv_pkg::MIN_FRAME_FLOOR : cfg.min_frame_bytes;
      verdict.frame_id     = id_ff;
      verdict.record_count = declared_ff;
      priority if (frame_len < tfv_pkg::COUNT_BITS'(min_len)) begin
         verdict.fault_code = tfv_pkg::FAULT_SHORT;
      end else if (fault_ff != tfv_pkg::FAULT_NONE) begin
         verdict.fault_code = fault_ff;
      end else if (phase_ff == PH_REC_ID || phase_ff == PH_REC_LEN) begin
         verdict.fault_code = tfv_pkg::FAULT_HEADER;
      end else if (phase_ff == PH_PAYLOAD) begin
         verdict.fault_code = tfv_pkg::FAULT_PAYLOAD;
      end else if (phase_ff != PH_TRAILER) begin
         verdict.fault_code = tfv_pkg::FAULT_LENGTH;
      end else if (crc_ff != rx_byte) begin
         verdict.fault_code = tfv_pkg::FAULT_CRC;
      end else begin
         verdict.fault_code = tfv_pkg::FAULT_NONE;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      bytes_in    = bytes_ff;
      crc_in      = crc_ff;
      id_in       = id_ff;
      declared_in = declared_ff;
      done_in     = done_ff;
      left_in     = left_ff;
      fault_in    = fault_ff;
      if (step) begin
         if (last) begin
            phase_in    = PH_START;
            bytes_in    = '0;
            crc_in      = tfv_pkg::CRC_INIT;
            id_in       = '0;
            declared_in = '0;
            done_in     = '0;
            left_in     = '0;
            fault_in    = tfv_pkg::FAULT_NONE;
         end else begin
            if (bytes_ff == POS_ID)    id_in       = rx_byte;
            if (bytes_ff == POS_COUNT) declared_in = rx_byte;
            if (fault_ff == tfv_pkg::FAULT_NONE) begin
               phase_in = phase_walk;
               done_in  = done_walk;
               left_in  = left_walk;
               fault_in = fault_walk;
            end
            crc_in = tfv_pkg::crc8_next(crc_ff, rx_byte);
            if (!saturated) bytes_in = bytes_ff + tfv_pkg::COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         bytes_ff    <= '0;
         crc_ff      <= tfv_pkg::CRC_INIT;
         id_ff       <= '0;
         declared_ff <= '0;
         done_ff     <= '0;
         left_ff     <= '0;
         fault_ff    <= tfv_pkg::FAULT_NONE;
      end else begin
         phase_ff    <= phase_in;
         bytes_ff    <= bytes_in;
         crc_ff      <= crc_in;
         id_ff       <= id_in;
         declared_ff <= declared_in;
         done_ff     <= done_in;
         left_ff     <= left_in;
         fault_ff    <= fault_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> bytes_ff == '0 && fault_ff == tfv_pkg::FAULT_NONE && phase_ff == PH_START)
      else $error("frame state not cleared after final byte");

   a_header_fault_only: assert property (@(posedge clock) disable iff (reset)
      fault_ff == tfv_pkg::FAULT_NONE || fault_ff == tfv_pkg::FAULT_START ||
      fault_ff == tfv_pkg::FAULT_ID || fault_ff == tfv_pkg::FAULT_COUNT)
      else $error("stored fault is not a header fault");

   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      step && !last && !saturated |=> bytes_ff == $past(bytes_ff) + tfv_pkg::COUNT_BITS'(1))
      else $error("byte counter did not advance");

   a_fault_freezes_walk: assert property (@(posedge clock) disable iff (reset)
      step && !last && fault_ff != tfv_pkg::FAULT_NONE |=> $stable(phase_ff) && $stable(fault_ff))
      else $error("record walk moved after header fault");

endmodule

### sv/tlv_frame_validator.sv
// Top level of the TLV frame validator: input register, parser and result register.
// A final byte is held in the input register, its verdict in the result register for rsp.
// One byte per cycle when not stalled; the parser updates its frame state once per byte.
// The input register keeps taking bytes while a verdict waits in the result register,
// and stalls only when a final byte meets a result register that is still full.
// Reset clears the frame state, empties both registers and restores register defaults.
module tlv_frame_validator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tfv_pkg::BYTE_BITS-1:0]        req_tdata,  // [7:0] rx_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tfv_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // [3:0] fault_code, [11:4] frame_id,
                                                            // [19:12] record_count, [23:20] zero
   output logic                                 rsp_tuser,  // [0] frame_ok
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tfv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tfv_pkg::BYTE_BITS-1:0]        csr_data
);

   tfv_pkg::cfg_type             cfg;
   tfv_pkg::verdict_type         verdict;
   tfv_pkg::verdict_type         out_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         item_valid;
   logic [tfv_pkg::BYTE_BITS-1:0] item_byte;
   logic                         item_last;
   logic                         advance;
   logic                         out_load;

   assign advance      = item_valid && (!item_last || !out_valid_ff || rsp_tready);
   assign out_load     = advance && item_last;
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   tfv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tfv_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .advance    (advance),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .item_last  (item_last)
   );

   tfv_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (item_byte),
      .last    (item_last),
      .cfg     (cfg),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= verdict;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = (out_ff.fault_code == tfv_pkg::FAULT_NONE);
   assign rsp_tdata  = {4'd0, out_ff.record_count, out_ff.frame_id, out_ff.fault_code};

   a_no_load_over_full: assert property (@(posedge clock) disable iff (reset)
      out_load && out_valid_ff |-> rsp_tready)
      else $error("verdict loaded over an untaken verdict");

   a_fault_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_ff.fault_code <= tfv_pkg::FAULT_CRC)
      else $error("fault code out of range");

   a_verdict_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(advance && item_last))
      else $error("verdict without a final byte");

endmodule
